[hdl/asse_pkg.sv]
// ----------------------------------------------------------------------------
// asse_pkg
// Shared types, constants and the segment table of the auto-ranging
// four-digit seven-segment encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asse_pkg;

	localparam int unsigned VALUE_W    = 24;
	localparam int unsigned DIGITS_W   = 14;
	localparam int unsigned SEG_W      = 8;
	localparam int unsigned SEG_DP_BIT = 3;
	localparam int unsigned RECIP_W    = 25;
	localparam int unsigned PROD_W     = VALUE_W + RECIP_W;
	localparam int unsigned SPLIT_W    = 17;
	localparam int unsigned SPLIT_PW   = DIGITS_W + SPLIT_W;

	// range edges, in thousandths
	localparam logic [VALUE_W-1:0] LIMIT_X_XXX = 24'd10000;
	localparam logic [VALUE_W-1:0] LIMIT_XX_XX = 24'd100000;
	localparam logic [VALUE_W-1:0] LIMIT_XXX_X = 24'd1000000;
	localparam logic [VALUE_W-1:0] SAT_LIMIT   = 24'd9999000;
	localparam logic [DIGITS_W-1:0] SAT_DIGITS = 14'd9999;

	// reciprocals for range scaling: q = (v * M) >> K
	localparam logic [RECIP_W-1:0] RECIP10_M   = 25'd104858;
	localparam int unsigned        RECIP10_K   = 20;
	localparam logic [RECIP_W-1:0] RECIP100_M  = 25'd1342178;
	localparam int unsigned        RECIP100_K  = 27;
	localparam logic [RECIP_W-1:0] RECIP1000_M = 25'd17179870;
	localparam int unsigned        RECIP1000_K = 34;

	// reciprocals for digit split of a value below 10000
	localparam logic [SPLIT_W-1:0] SPLIT10_M   = 17'd13108;
	localparam int unsigned        SPLIT10_K   = 17;
	localparam logic [SPLIT_W-1:0] SPLIT100_M  = 17'd5243;
	localparam int unsigned        SPLIT100_K  = 19;
	localparam logic [SPLIT_W-1:0] SPLIT1000_M = 17'd8389;
	localparam int unsigned        SPLIT1000_K = 23;

	// decimal point position
	localparam logic [1:0] DP_THOUSANDS = 2'd0;
	localparam logic [1:0] DP_HUNDREDS  = 2'd1;
	localparam logic [1:0] DP_TENS      = 2'd2;
	localparam logic [1:0] DP_NONE      = 2'd3;

	typedef logic [1:0] dp_slot_t;

	typedef struct packed {
		logic [DIGITS_W-1:0] digits;
		dp_slot_t            dp_slot;
	} scaled_t;

	typedef struct packed {
		logic [SEG_W-1:0] thousands;
		logic [SEG_W-1:0] hundreds;
		logic [SEG_W-1:0] tens;
		logic [SEG_W-1:0] units;
	} seg_word_t;

	// EDCFdpGBA
	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
		logic [SEG_W-1:0] seg;
		unique case (digit)
			4'd0:    seg = 8'hF3;
			4'd1:    seg = 8'h22;
			4'd2:    seg = 8'hC7;
			4'd3:    seg = 8'h67;
			4'd4:    seg = 8'h36;
			4'd5:    seg = 8'h75;
			4'd6:    seg = 8'hF5;
			4'd7:    seg = 8'h23;
			4'd8:    seg = 8'hF7;
			4'd9:    seg = 8'h77;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

`default_nettype wire

[hdl/asse_digit_encode.sv]
// ----------------------------------------------------------------------------
// asse_digit_encode
// Splits a four-digit value into decimal digits, maps each to its segment
// byte and sets the decimal point of the selected digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asse_digit_encode
	import asse_pkg::*;
(
	input  var scaled_t   scaled,
	output var seg_word_t segs
);

	logic [SPLIT_PW-1:0] prod10, prod100, prod1000;
	logic [9:0]          q1;
	logic [6:0]          q2;
	logic [3:0]          q3;
	logic [DIGITS_W-1:0] r0_full;
	logic [9:0]          r1_full;
	logic [6:0]          r2_full;
	logic [3:0]          d0, d1, d2;
	seg_word_t           raw;

	always_comb begin
		prod10   = SPLIT_PW'(scaled.digits) * SPLIT_PW'(SPLIT10_M);
		prod100  = SPLIT_PW'(scaled.digits) * SPLIT_PW'(SPLIT100_M);
		prod1000 = SPLIT_PW'(scaled.digits) * SPLIT_PW'(SPLIT1000_M);
		q1 = prod10[SPLIT10_K +: 10];
		q2 = prod100[SPLIT100_K +: 7];
		q3 = prod1000[SPLIT1000_K +: 4];

		// remainder: x - 10*q, with 10*q = 8q + 2q
		r0_full = scaled.digits - ({1'b0, q1, 3'b000} + {3'b000, q1, 1'b0});
		r1_full = q1 - ({q2, 3'b000} + {2'b00, q2, 1'b0});
		r2_full = q2 - ({q3, 3'b000} + {2'b00, q3, 1'b0});
		d0 = r0_full[3:0];
		d1 = r1_full[3:0];
		d2 = r2_full[3:0];

		raw.thousands = seg_of(q3);
		raw.hundreds  = seg_of(d2);
		raw.tens      = seg_of(d1);
		raw.units     = seg_of(d0);

		segs = raw;
		unique case (scaled.dp_slot)
			DP_THOUSANDS: segs.thousands[SEG_DP_BIT] = 1'b1;
			DP_HUNDREDS:  segs.hundreds[SEG_DP_BIT]  = 1'b1;
			DP_TENS:      segs.tens[SEG_DP_BIT]      = 1'b1;
			default:      ;
		endcase
	end

endmodule

`default_nettype wire

[hdl/autorange_seven_segment_encoder.sv]
// ----------------------------------------------------------------------------
// autorange_seven_segment_encoder
// Encodes a reading in thousandths of a unit as four seven-segment bytes
// with an auto-ranged decimal point.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   busy is always low, so a new reading may be issued every cycle.
//   value_milli is the reading; readings above 9999000 show as 9999.
//   Pipeline: input register (_s1), range scaling by one reciprocal
//   multiplier into the scaled register (_s2), digit split, segment lookup
//   and decimal point into the result register. A reading taken with
//   start high moves through valid_s1 and valid_s2 to done, which is high
//   together with seg_thousands..seg_units, valid for that one cycle only.
//   Throughput: one reading per cycle, bounded by the scaling multiplier
//   stage and the digit-split stage.
//   The receiver cannot stall; every result is shown exactly once.
//   Reset (arst_n low) clears the pipeline valid bits; readings in flight
//   are dropped and done stays low until a new transaction arrives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module autorange_seven_segment_encoder
	import asse_pkg::*;
(
	input  var logic               clk,
	input  var logic               arst_n,
	input  var logic               start,
	output var logic               busy,
	input  var logic [VALUE_W-1:0] value_milli,
	output var logic               done,
	output var logic [SEG_W-1:0]   seg_thousands,
	output var logic [SEG_W-1:0]   seg_hundreds,
	output var logic [SEG_W-1:0]   seg_tens,
	output var logic [SEG_W-1:0]   seg_units
);

	logic               valid_s1, valid_s2, done_q;
	logic [VALUE_W-1:0] value_s1;
	scaled_t            scaled_s2, scaled_d;
	seg_word_t          segs_d, segs_q;
	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0]  prod;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			value_s1 <= value_milli;
		end
		scaled_s2 <= scaled_d;
		segs_q    <= segs_d;
	end

	always_comb begin
		if (value_s1 < LIMIT_XX_XX) begin
			recip = RECIP10_M;
		end else if (value_s1 < LIMIT_XXX_X) begin
			recip = RECIP100_M;
		end else begin
			recip = RECIP1000_M;
		end
		prod = PROD_W'(value_s1) * PROD_W'(recip);

		if (value_s1 > SAT_LIMIT) begin
			scaled_d.digits  = SAT_DIGITS;
			scaled_d.dp_slot = DP_NONE;
		end else if (value_s1 < LIMIT_X_XXX) begin
			scaled_d.digits  = value_s1[DIGITS_W-1:0];
			scaled_d.dp_slot = DP_THOUSANDS;
		end else if (value_s1 < LIMIT_XX_XX) begin
			scaled_d.digits  = prod[RECIP10_K +: DIGITS_W];
			scaled_d.dp_slot = DP_HUNDREDS;
		end else if (value_s1 < LIMIT_XXX_X) begin
			scaled_d.digits  = prod[RECIP100_K +: DIGITS_W];
			scaled_d.dp_slot = DP_TENS;
		end else begin
			scaled_d.digits  = prod[RECIP1000_K +: DIGITS_W];
			scaled_d.dp_slot = DP_NONE;
		end
	end

	asse_digit_encode u_encode (
		.scaled (scaled_s2),
		.segs   (segs_d)
	);

	assign done          = done_q;
	assign seg_thousands = segs_q.thousands;
	assign seg_hundreds  = segs_q.hundreds;
	assign seg_tens      = segs_q.tens;
	assign seg_units     = segs_q.units;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result missing three cycles after transaction");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s2))
		else $error("result without a transaction in flight");

	a_single_dp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($countones({seg_thousands[SEG_DP_BIT], seg_hundreds[SEG_DP_BIT],
			seg_tens[SEG_DP_BIT]}) <= 1 && !seg_units[SEG_DP_BIT]))
		else $error("more than one decimal point shown");

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the auto-ranging seven-segment encoder. Readings
// are issued with random gaps, each accepted transaction is encoded by a
// local model, and every done strobe is checked against the oldest pending
// readout, comparing all four segment bytes together.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import asse_pkg::*;

	localparam int unsigned N_RANDOM    = 1150;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_WAIT  = 8;

	class readout_board;
		seg_word_t   expected_readouts[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		function logic [SEG_W-1:0] glyph(int unsigned d);
			logic [SEG_W-1:0] g;
			case (d)
				0:       g = 8'b11110011;
				1:       g = 8'b00100010;
				2:       g = 8'b11000111;
				3:       g = 8'b01100111;
				4:       g = 8'b00110110;
				5:       g = 8'b01110101;
				6:       g = 8'b11110101;
				7:       g = 8'b00100011;
				8:       g = 8'b11110111;
				default: g = 8'b01110111;
			endcase
			return g;
		endfunction

		function seg_word_t encode_reading(logic [VALUE_W-1:0] v);
			int unsigned shown;
			dp_slot_t    dp;
			seg_word_t   w;
			if (v < LIMIT_X_XXX) begin
				shown = 32'(v);
				dp = DP_THOUSANDS;
			end else if (v < LIMIT_XX_XX) begin
				shown = v / 10;
				dp = DP_HUNDREDS;
			end else if (v < LIMIT_XXX_X) begin
				shown = v / 100;
				dp = DP_TENS;
			end else begin
				shown = v / 1000;
				dp = DP_NONE;
			end
			if (v > SAT_LIMIT) begin
				shown = 32'(SAT_DIGITS);
				dp = DP_NONE;
			end
			w.thousands = glyph((shown / 1000) % 10);
			w.hundreds  = glyph((shown / 100) % 10);
			w.tens      = glyph((shown / 10) % 10);
			w.units     = glyph(shown % 10);
			if (dp == DP_THOUSANDS)
				w.thousands[SEG_DP_BIT] = 1'b1;
			else if (dp == DP_HUNDREDS)
				w.hundreds[SEG_DP_BIT] = 1'b1;
			else if (dp == DP_TENS)
				w.tens[SEG_DP_BIT] = 1'b1;
			return w;
		endfunction

		function void note_reading(logic [VALUE_W-1:0] v);
			expected_readouts.push_back(encode_reading(v));
		endfunction

		function int unsigned pending();
			return expected_readouts.size();
		endfunction

		function void check_readout(seg_word_t got);
			seg_word_t want;
			if (expected_readouts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected readout %h", $realtime, got);
				return;
			end
			want = expected_readouts.pop_front();
			if (got.thousands !== want.thousands || got.hundreds !== want.hundreds ||
					got.tens !== want.tens || got.units !== want.units) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: readout mismatch exp %h %h %h %h got %h %h %h %h",
						$realtime, want.thousands, want.hundreds, want.tens, want.units,
						got.thousands, got.hundreds, got.tens, got.units);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VALUE_W-1:0] value_milli;
	logic               done;
	logic [SEG_W-1:0]   seg_thousands;
	logic [SEG_W-1:0]   seg_hundreds;
	logic [SEG_W-1:0]   seg_tens;
	logic [SEG_W-1:0]   seg_units;

	readout_board board = new();
	int unsigned  cycle_count = 0;

	autorange_seven_segment_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value_milli  (value_milli),
		.done         (done),
		.seg_thousands(seg_thousands),
		.seg_hundreds (seg_hundreds),
		.seg_tens     (seg_tens),
		.seg_units    (seg_units)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_reading(value_milli);
			if (done)
				board.check_readout({seg_thousands, seg_hundreds, seg_tens, seg_units});
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_reading(logic [VALUE_W-1:0] v);
		int unsigned gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value_milli <= v;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		while (board.pending() > 0)
			@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] random_reading();
		logic [VALUE_W-1:0] edges[5];
		logic [VALUE_W-1:0] v;
		edges = '{LIMIT_X_XXX, LIMIT_XX_XX, LIMIT_XXX_X, SAT_LIMIT, 24'd0};
		case ($urandom_range(0, 5))
			0:       v = VALUE_W'($urandom_range(0, 9999));
			1:       v = VALUE_W'($urandom_range(10000, 99999));
			2:       v = VALUE_W'($urandom_range(100000, 999999));
			3:       v = VALUE_W'($urandom_range(1000000, 9999000));
			4:       v = VALUE_W'($urandom());
			default: v = VALUE_W'(edges[$urandom_range(0, 4)] + $urandom_range(0, 4) - 2);
		endcase
		return v;
	endfunction

	initial begin
		logic [VALUE_W-1:0] directed[$];
		directed = '{24'd0, 24'd1, 24'd1234, 24'd5678, 24'd9999, 24'd10000, 24'd10001,
			24'd99999, 24'd100000, 24'd100001, 24'd999999, 24'd1000000, 24'd1000999,
			24'd4567890, 24'd9999000, 24'd9999001, 24'd9999999, 24'd10000000,
			24'h555555, 24'hAAAAAA, 24'h800000, 24'hFFFFFF};
		arst_n = 1'b0;
		start = 1'b0;
		value_milli = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_reading(directed[i]);

		for (int unsigned n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				start <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
			send_reading(random_reading());
		end

		start <= 1'b0;
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		if (board.mismatches == 0 && board.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
